[hdl/bcps_pkg.sv]
// Package for the block column pivot search: payload structs and constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bcps_pkg;
    localparam int unsigned MAX_BLOCKS = 1024;
    localparam logic [30:0] INF_MAG = 31'h7F80_0000;

    typedef struct packed {
        logic [31:0] value_0;
        logic [31:0] value_1;
        logic [31:0] value_2;
        logic [31:0] value_3;
        logic        last;
    } in_item_t;

    typedef struct packed {
        logic [11:0] pivot_row_0;
        logic [11:0] pivot_row_1;
        logic [11:0] pivot_row_2;
        logic [11:0] pivot_row_3;
        logic        overflow;
    } out_item_t;

    // strict greater on sign-cleared words; false if either is NaN
    function automatic logic mag_greater(input logic [30:0] a, input logic [30:0] b);
        mag_greater = (a <= INF_MAG) && (b <= INF_MAG) && (a > b);
    endfunction
endpackage
`default_nettype wire

[hdl/bcps_tree.sv]
// Four-way magnitude compare tree; earlier rows win ties.
// Depends on bcps_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bcps_tree (
    input  wire bcps_pkg::in_item_t item,
    output logic [30:0]             max_mag,
    output logic [1:0]              max_idx
);
    import bcps_pkg::*;
    logic [30:0] v0, v1, v2, v3, m01, m23;
    logic [1:0]  i01, i23;
    always_comb begin
        v0 = item.value_0[30:0];
        v1 = item.value_1[30:0];
        v2 = item.value_2[30:0];
        v3 = item.value_3[30:0];
        if (mag_greater(v1, v0)) begin m01 = v1; i01 = 2'd1; end
        else begin m01 = v0; i01 = 2'd0; end
        if (mag_greater(v3, v2)) begin m23 = v3; i23 = 2'd3; end
        else begin m23 = v2; i23 = 2'd2; end
        if (mag_greater(m23, m01)) begin max_mag = m23; max_idx = i23; end
        else begin max_mag = m01; max_idx = i01; end
    end
endmodule
`default_nettype wire

[hdl/block_column_pivot_search.sv]
// Top level of the block column pivot search: input register, running bests,
// result register. Depends on bcps_pkg and bcps_tree.
//
//  channel  | ports             | payload
//  config   | cfg_valid/ready   | cfg_data (start_block, 10 bits)
//  input    | s_valid/s_ready   | s_data (in_item_t)
//  result   | m_valid/m_ready   | m_data (out_item_t)
// One block column per cycle unless the input stalls; a request waits in the
// input register, then updates the bests or, if last, loads the result
// register, so a result passes through both registers after acceptance.
// The rate is set by the combinational tree plus accumulator compare.
// Reset is synchronous on aresetn; the input stalls only when the result
// register is full and not taken and the input register holds a last item.
// A config write waits while the input register holds a request.
`timescale 1ns / 1ps
`default_nettype none
module block_column_pivot_search (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     cfg_valid,
    output logic                    cfg_ready,
    input  wire  [9:0]              cfg_data,
    input  wire                     s_valid,
    output logic                    s_ready,
    input  wire bcps_pkg::in_item_t s_data,
    output logic                    m_valid,
    input  wire                     m_ready,
    output bcps_pkg::out_item_t     m_data
);
    import bcps_pkg::*;

    logic        in_valid_reg;
    in_item_t    in_data_reg;
    logic [9:0]  start_reg;
    logic [30:0] best_mag_reg [4];
    logic [3:0]  best_valid_reg;
    logic [11:0] best_row_reg [4];
    logic [1:0]  col_reg;
    logic [9:0]  blk_reg;
    logic        ovf_reg;
    logic        m_valid_reg;
    out_item_t   m_data_reg;

    logic [30:0] max_mag;
    logic [1:0]  max_idx;
    logic        fire, emit, upd, ovf_now;
    logic [11:0] row_new, restart_row;
    logic [9:0]  blk_inc;

    bcps_tree u_tree (.item(in_data_reg), .max_mag(max_mag), .max_idx(max_idx));

    // stage advances unless a last item waits on a full result register
    assign emit = in_valid_reg && in_data_reg.last;
    assign fire = in_valid_reg && !(emit && m_valid_reg && !m_ready);
    assign s_ready = !in_valid_reg || fire;
    assign cfg_ready = !in_valid_reg;
    assign m_valid = m_valid_reg;
    assign m_data = m_data_reg;

    assign restart_row = {start_reg, 2'b00};
    assign row_new = {blk_reg, max_idx};
    assign blk_inc = blk_reg + 10'd1;
    assign upd = (max_mag <= INF_MAG) &&
                 (!best_valid_reg[col_reg] || mag_greater(max_mag, best_mag_reg[col_reg]));
    assign ovf_now = ovf_reg || (32'(blk_reg) >= 32'(MAX_BLOCKS)) ||
                     ((col_reg == 2'd3) && (blk_inc == 10'd0));

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) in_data_reg <= s_data;
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            start_reg <= '0;
            best_valid_reg <= '0;
            col_reg <= '0;
            blk_reg <= '0;
            ovf_reg <= 1'b0;
            for (int c = 0; c < 4; c++) best_row_reg[c] <= '0;
        end else begin
            if (s_ready) in_valid_reg <= s_valid;
            if (fire && emit) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
            if (cfg_valid && cfg_ready) begin
                start_reg <= cfg_data;
                best_valid_reg <= '0;
                col_reg <= '0;
                blk_reg <= cfg_data;
                ovf_reg <= 1'b0;
                for (int c = 0; c < 4; c++) best_row_reg[c] <= {cfg_data, 2'b00};
            end else if (fire) begin
                if (emit) begin
                    // restart the search; output takes this item's update
                    m_data_reg.pivot_row_0 <= (upd && col_reg == 2'd0) ? row_new : best_row_reg[0];
                    m_data_reg.pivot_row_1 <= (upd && col_reg == 2'd1) ? row_new : best_row_reg[1];
                    m_data_reg.pivot_row_2 <= (upd && col_reg == 2'd2) ? row_new : best_row_reg[2];
                    m_data_reg.pivot_row_3 <= (upd && col_reg == 2'd3) ? row_new : best_row_reg[3];
                    m_data_reg.overflow <= ovf_now;
                    best_valid_reg <= '0;
                    col_reg <= '0;
                    blk_reg <= start_reg;
                    ovf_reg <= 1'b0;
                    for (int c = 0; c < 4; c++) best_row_reg[c] <= restart_row;
                end else begin
                    if (upd) begin
                        best_mag_reg[col_reg] <= max_mag;
                        best_valid_reg[col_reg] <= 1'b1;
                        best_row_reg[col_reg] <= row_new;
                    end
                    col_reg <= col_reg + 2'd1;
                    if (col_reg == 2'd3) blk_reg <= blk_inc;
                    ovf_reg <= ovf_now;
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");
    a_emit_only_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(emit))
        else $error("result without last item");
    a_restart_col: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && emit |=> col_reg == 2'd0 && best_valid_reg == 4'd0)
        else $error("search did not restart");
`endif
endmodule
`default_nettype wire

[dv/tb.sv]
// Testbench for block_column_pivot_search: directed table, then random block-column
// streams checked against an in-bench pivot search predictor. Depends on bcps_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import bcps_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int NUM_RANDOM = 700;
    localparam logic [31:0] QNAN = 32'h7FC0_0000;
    localparam logic [31:0] PINF = 32'h7F80_0000;
    localparam logic [31:0] NINF = 32'hFF80_0000;

    logic aclk;
    logic aresetn;
    logic cfg_valid;
    logic cfg_ready;
    logic [9:0] cfg_data;
    logic s_valid;
    logic s_ready;
    in_item_t s_data;
    logic m_valid;
    logic m_ready;
    out_item_t m_data;

    block_column_pivot_search u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // predictor state
    logic [9:0]  start_blk;
    logic [30:0] best_mag [4];
    logic        best_ok [4];
    logic [11:0] best_row [4];
    logic [1:0]  col_cnt;
    logic [9:0]  blk_cnt;
    logic        ovf_seen;

    out_item_t pivot_q[$];
    int mismatches;
    int idle_cycles;
    bit timed_out;
    bit hold_off;

    typedef struct {
        in_item_t    item;
        bit          typed;
        out_item_t   typed_out;
    } stim_row_t;

    function automatic logic nan_safe_gt(logic [30:0] a, logic [30:0] b);
        if (a > PINF[30:0] || b > PINF[30:0]) return 1'b0;
        return a > b;
    endfunction

    task automatic restart_search();
        for (int c = 0; c < 4; c++) begin
            best_mag[c] = '0;
            best_ok[c] = 1'b0;
            best_row[c] = {start_blk, 2'b00};
        end
        col_cnt = '0;
        blk_cnt = start_blk;
        ovf_seen = 1'b0;
    endtask

    // advance the predictor by one block column; return a pivot set on last
    task automatic predict_pivots(input in_item_t it, output bit emitted, output out_item_t res);
        logic [30:0] v [4];
        logic [30:0] m01, m23, ml;
        logic [1:0]  i01, i23, il;
        v[0] = it.value_0[30:0];
        v[1] = it.value_1[30:0];
        v[2] = it.value_2[30:0];
        v[3] = it.value_3[30:0];
        if (blk_cnt >= MAX_BLOCKS) ovf_seen = 1'b1;
        if (nan_safe_gt(v[1], v[0])) begin i01 = 1; m01 = v[1]; end
        else begin i01 = 0; m01 = v[0]; end
        if (nan_safe_gt(v[3], v[2])) begin i23 = 3; m23 = v[3]; end
        else begin i23 = 2; m23 = v[2]; end
        if (nan_safe_gt(m23, m01)) begin il = i23; ml = m23; end
        else begin il = i01; ml = m01; end
        if (ml <= PINF[30:0] && (!best_ok[col_cnt] || nan_safe_gt(ml, best_mag[col_cnt]))) begin
            best_mag[col_cnt] = ml;
            best_ok[col_cnt] = 1'b1;
            best_row[col_cnt] = {blk_cnt, il};
        end
        if (col_cnt == 2'd3) begin
            col_cnt = '0;
            blk_cnt = blk_cnt + 10'd1;
            if (blk_cnt == 10'd0) ovf_seen = 1'b1;
        end else begin
            col_cnt = col_cnt + 2'd1;
        end
        emitted = it.last;
        res = '0;
        if (it.last) begin
            res.pivot_row_0 = best_row[0];
            res.pivot_row_1 = best_row[1];
            res.pivot_row_2 = best_row[2];
            res.pivot_row_3 = best_row[3];
            res.overflow = ovf_seen;
            restart_search();
        end
    endtask

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pivot_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", m_data);
            end else begin
                out_item_t exp_r;
                exp_r = pivot_q.pop_front();
                if (m_data.pivot_row_0 !== exp_r.pivot_row_0 ||
                    m_data.pivot_row_1 !== exp_r.pivot_row_1 ||
                    m_data.pivot_row_2 !== exp_r.pivot_row_2 ||
                    m_data.pivot_row_3 !== exp_r.pivot_row_3 ||
                    m_data.overflow !== exp_r.overflow) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("pivot mismatch: exp %h/%h/%h/%h ovf %b, got %h/%h/%h/%h ovf %b",
                            exp_r.pivot_row_0, exp_r.pivot_row_1, exp_r.pivot_row_2,
                            exp_r.pivot_row_3, exp_r.overflow,
                            m_data.pivot_row_0, m_data.pivot_row_1, m_data.pivot_row_2,
                            m_data.pivot_row_3, m_data.overflow);
                end
            end
        end
    end

    // watchdog: count cycles with no handshake on any channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver: own stall pattern, plus a long hold-off on request
    initial begin
        int mode;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_off) begin
                m_ready <= 1'b0;
            end else begin
                mode = $urandom_range(0, 99);
                m_ready <= (mode < 60) || (($urandom_range(0, 3)) != 0 && mode < 85);
            end
        end
    end

    task automatic send_item(input in_item_t it);
        bit em;
        out_item_t r;
        s_valid <= 1'b1;
        s_data <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_pivots(it, em, r);
        if (em) pivot_q.push_back(r);
        @(negedge aclk);
    endtask

    // random gap between bursts
    task automatic maybe_gap(inout int burst_left);
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        s_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge aclk);
        burst_left = $urandom_range(0, 12);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pivot_q.size() != 0) @(negedge aclk);
        repeat (6) @(negedge aclk);
    endtask

    task automatic write_start(input logic [9:0] sb);
        cfg_valid <= 1'b1;
        cfg_data <= sb;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        start_blk = sb;
        restart_search();
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_word();
        int k;
        k = $urandom_range(0, 19);
        case (k)
            0: return QNAN | $urandom_range(0, 32'h3F_FFFF) | ($urandom_range(0, 1) << 31);
            1: return ($urandom_range(0, 1)) ? PINF : NINF;
            2: return {$urandom_range(0, 1) == 1, 31'h0};
            3: return 32'h3F80_0000 | ($urandom_range(0, 1) << 31);
            4, 5, 6: return {$urandom_range(0, 1) == 1, 8'h7F, 20'h0, 3'($urandom_range(0, 7))};
            default: return $urandom();
        endcase
    endfunction

    function automatic in_item_t mk(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                                    logic [31:0] d, logic l);
        in_item_t it;
        it.value_0 = a; it.value_1 = b; it.value_2 = c; it.value_3 = d; it.last = l;
        return it;
    endfunction

    initial begin
        stim_row_t rows[$];
        stim_row_t r;
        in_item_t it;
        int burst;
        int ncols;
        bit em;
        out_item_t pr;

        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        s_valid = 1'b0;
        s_data = '0;
        hold_off = 1'b0;
        mismatches = 0;
        start_blk = '0;
        restart_search();
        repeat (7) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // directed table; typed rows are easy to read off, others use the predictor
        r.typed = 0; r.typed_out = '0;
        // last right after reset, all zero: row 0 wins in column 0
        r.item = mk(0, 0, 0, 0, 1); r.typed = 1; r.typed_out = '0; rows.push_back(r);
        // all NaN in one column: nothing qualifies, default rows
        r.item = mk(QNAN, QNAN, 32'hFFFF_FFFF, 32'h7F80_0001, 1); r.typed = 1;
        r.typed_out = '0; rows.push_back(r);
        r.typed = 0;
        // full block: ties, sign, infinity
        r.item = mk(32'hBF80_0000, 32'h3F80_0000, 32'h3F80_0000, 32'h0, 0); rows.push_back(r);
        r.item = mk(32'h0, 32'h0, NINF, PINF, 0); rows.push_back(r);
        r.item = mk(QNAN, 32'h4000_0000, 32'h4000_0000, QNAN, 0); rows.push_back(r);
        r.item = mk(32'h0000_0001, 32'h8000_0002, 32'h7F7F_FFFF, 32'hFF7F_FFFF, 0);
        rows.push_back(r);
        // second block: beats and non-beats of running best
        r.item = mk(32'h4000_0000, 0, 0, 0, 0); rows.push_back(r);
        r.item = mk(PINF, 0, 0, 0, 0); rows.push_back(r);
        r.item = mk(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 0);
        rows.push_back(r);
        r.item = mk(32'h5555_5555, 32'hAAAA_AAAA, 32'h3333_3333, 32'hCCCC_CCCC, 1);
        rows.push_back(r);
        // early last on column 1
        r.item = mk(0, 32'h3F80_0000, 0, 0, 0); rows.push_back(r);
        r.item = mk(0, 0, 32'h3F80_0000, 0, 1); rows.push_back(r);

        foreach (rows[i]) begin
            if (rows[i].typed) begin
                // keep the predictor in step, expect the typed result
                it = rows[i].item;
                s_valid <= 1'b1;
                s_data <= it;
                @(posedge aclk);
                while (!s_ready) @(posedge aclk);
                predict_pivots(it, em, pr);
                pivot_q.push_back(rows[i].typed_out);
                @(negedge aclk);
            end else begin
                send_item(rows[i].item);
            end
        end
        drain();

        // extremes of start_block and the wrap-driven overflow
        write_start(10'd1023);
        for (int i = 0; i < 8; i++)
            send_item(mk(rand_word(), rand_word(), rand_word(), rand_word(), i == 7));
        send_item(mk(0, 0, 0, 0, 1));
        drain();

        // long receiver hold-off while the sender keeps pushing last items
        write_start(10'd3);
        hold_off = 1'b1;
        fork
            begin
                for (int i = 0; i < 6; i++)
                    send_item(mk(rand_word(), rand_word(), rand_word(), rand_word(), 1'b1));
            end
            begin
                repeat (200) @(negedge aclk);
                hold_off = 1'b0;
            end
        join
        drain();

        // random streams across several start settings
        burst = 0;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: write_start(10'd0);
                1: write_start(10'($urandom_range(1, 1022)));
                2: write_start(10'd1020);
                default: write_start(10'($urandom()));
            endcase
            for (int n = 0; n < NUM_RANDOM / 4; ) begin
                // mostly whole blocks, sometimes an early last
                ncols = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 12)
                                                    : 4 * $urandom_range(1, 4);
                for (int c = 0; c < ncols; c++) begin
                    send_item(mk(rand_word(), rand_word(), rand_word(), rand_word(),
                                 c == ncols - 1));
                    n++;
                    maybe_gap(burst);
                end
            end
            drain();
        end

        // leftover expectations count as failures
        if (pivot_q.size() != 0) mismatches++;

        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
`default_nettype wire
